/* rtl/core/lcts_pkg.sv */
// Shared request/response types and request codes for the lock and condvar scheduler.
package lcts_pkg;

  localparam logic [3:0] MODE_START     = 4'd0;
  localparam logic [3:0] MODE_CREATE    = 4'd1;
  localparam logic [3:0] MODE_YIELD     = 4'd2;
  localparam logic [3:0] MODE_LOCK      = 4'd3;
  localparam logic [3:0] MODE_UNLOCK    = 4'd4;
  localparam logic [3:0] MODE_WAIT      = 4'd5;
  localparam logic [3:0] MODE_SIGNAL    = 4'd6;
  localparam logic [3:0] MODE_BROADCAST = 4'd7;
  localparam logic [3:0] MODE_FINISH    = 4'd8;

  typedef struct packed {
    logic [1:0] cond_id;
    logic [3:0] lock_id;
    logic [3:0] mode;
  } req_t;

  typedef struct packed {
    logic [3:0] new_thread;
    logic       idle;
    logic [3:0] active_thread;
    logic       status;
  } resp_t;

endpackage

/* rtl/core/lcts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lcts_ctrl.sv */
// Request sequencer: scheduler state, queues and the step-by-step update engine.
module lcts_ctrl #(
  parameter int THREADS = 16,
  parameter int LOCKS   = 16,
  parameter int CONDS   = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  lcts_pkg::req_t   req,
  output logic             req_ready,
  output logic             resp_valid,
  output lcts_pkg::resp_t  resp
);

  localparam int TW = $clog2(THREADS);
  localparam int IW = TW + 1;
  localparam int CW = $clog2(THREADS + 1);
  localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
  localparam int PW = $clog2(LOCKS + 1);
  localparam int NQ = LOCKS * CONDS;
  localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;
  localparam logic [IW-1:0] NO_T = IW'(THREADS);
  localparam logic [IW-1:0] ORPH = IW'(THREADS + 1);
  localparam logic [PW-1:0] NO_L = PW'(LOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ALLOC, S_RELEASE, S_LQ_PUSH, S_WN_LINK, S_CV_READ,
    S_CV_PUSH, S_CV_POP, S_FINISH, S_DISPATCH, S_RELOCK, S_RESP
  } state_t;

  state_t          state_r;
  logic [3:0]      mode_r;
  logic [LW-1:0]   lk_r;
  logic [QW-1:0]   qi_r;
  logic            lk_ok_r, cv_ok_r;
  logic            started_r;
  logic [TW-1:0]   cur_r;
  logic [THREADS-1:0] live_r;
  logic [TW-1:0]   rq_r [THREADS];
  logic [TW-1:0]   head_r;
  logic [CW-1:0]   cnt_r;
  logic [IW-1:0]   holder_r [LOCKS];
  logic [IW-1:0]   wnext_r [THREADS];
  logic [IW-1:0]   lqh_r [LOCKS];
  logic [IW-1:0]   lqt_r [LOCKS];
  logic [PW-1:0]   pend_r [THREADS];
  logic [NQ-1:0]   cv_vld_r;
  logic [TW-1:0]   scan_r;
  logic [LW-1:0]   lsel_r;
  logic [TW-1:0]   push_t_r;
  logic [TW-1:0]   link_r;
  logic [TW-1:0]   disp_t_r;
  logic            status_r, idle_r;
  logic [TW-1:0]   newt_r;

  logic [IW-1:0]   cur_x;
  logic [PW-1:0]   pend_cur;
  logic [LW-1:0]   hold_addr;
  logic [IW-1:0]   hold;
  logic [IW-1:0]   lq_h, lq_t;
  logic [2*IW-1:0] cv_rdata, cv_wdata;
  logic            cv_we;
  logic [IW-1:0]   cv_h, cv_t;
  logic [TW-1:0]   wn_addr;
  logic [IW-1:0]   wn;
  logic [CW:0]     rq_sum;
  logic [TW-1:0]   rq_widx, head_inc;
  logic            rq_push;
  logic [TW-1:0]   rq_val;

  assign cur_x     = IW'(cur_r);
  assign pend_cur  = pend_r[disp_t_r];
  assign hold_addr = (state_r == S_RELOCK) ? LW'(pend_cur) : lsel_r;
  assign hold      = holder_r[hold_addr];
  assign lq_h      = lqh_r[lsel_r];
  assign lq_t      = lqt_r[lsel_r];
  assign cv_h      = cv_vld_r[qi_r] ? cv_rdata[2*IW-1:IW] : NO_T;
  assign cv_t      = cv_vld_r[qi_r] ? cv_rdata[IW-1:0] : NO_T;
  assign wn_addr   = (state_r == S_CV_POP) ? TW'(cv_h) : TW'(lq_h);
  assign wn        = wnext_r[wn_addr];
  assign rq_sum    = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign rq_widx   = (rq_sum >= (CW+1)'(THREADS)) ? TW'(rq_sum - (CW+1)'(THREADS))
                                                  : TW'(rq_sum);
  assign head_inc  = (head_r == TW'(THREADS - 1)) ? '0 : head_r + TW'(1);

  // Ready-queue push and condition-queue write, one per cycle at most
  always_comb begin
    rq_push  = 1'b0;
    rq_val   = cur_r;
    cv_we    = 1'b0;
    cv_wdata = {NO_T, NO_T};
    case (state_r)
      S_DECODE: begin
        rq_push = started_r && (mode_r == lcts_pkg::MODE_YIELD);
      end
      S_ALLOC: begin
        rq_push = !live_r[scan_r] && (mode_r == lcts_pkg::MODE_CREATE);
        rq_val  = scan_r;
      end
      S_RELEASE: begin
        rq_push = (lq_h < NO_T);
        rq_val  = TW'(lq_h);
      end
      S_CV_PUSH: begin
        cv_we    = 1'b1;
        cv_wdata = (cv_h < NO_T) ? {cv_h, cur_x} : {cur_x, cur_x};
      end
      S_CV_POP: begin
        rq_push  = (cv_h < NO_T);
        rq_val   = TW'(cv_h);
        cv_we    = (cv_h < NO_T);
        cv_wdata = (wn < NO_T) ? {wn, cv_t} : {NO_T, NO_T};
      end
      default: begin
        rq_push = 1'b0;
      end
    endcase
  end

  lcts_ram #(
    .WIDTH (2 * IW),
    .DEPTH (NQ)
  ) u_cv_ram (
    .clk   (clk),
    .we    (cv_we),
    .waddr (qi_r),
    .wdata (cv_wdata),
    .raddr (qi_r),
    .rdata (cv_rdata)
  );

  assign req_ready  = (state_r == S_IDLE);
  assign resp_valid = (state_r == S_RESP);
  assign resp.status        = status_r;
  assign resp.active_thread = 4'(cur_r);
  assign resp.idle          = idle_r;
  assign resp.new_thread    = 4'(newt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      cur_r     <= '0;
      live_r    <= '0;
      head_r    <= '0;
      cnt_r     <= '0;
      cv_vld_r  <= '0;
      for (int i = 0; i < LOCKS; i++) begin
        holder_r[i] <= NO_T;
        lqh_r[i]    <= NO_T;
        lqt_r[i]    <= NO_T;
      end
      for (int i = 0; i < THREADS; i++) begin
        pend_r[i] <= NO_L;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            mode_r   <= req.mode;
            lk_r     <= LW'(req.lock_id);
            lsel_r   <= LW'(req.lock_id);
            qi_r     <= QW'(32'(req.lock_id) * CONDS + 32'(req.cond_id));
            lk_ok_r  <= (32'(req.lock_id) < LOCKS);
            cv_ok_r  <= (32'(req.lock_id) < LOCKS) && (32'(req.cond_id) < CONDS);
            status_r <= 1'b0;
            idle_r   <= 1'b0;
            newt_r   <= '0;
            state_r  <= S_DECODE;
          end
        end
        S_DECODE: begin
          scan_r <= '0;
          if (!started_r) begin
            if (mode_r == lcts_pkg::MODE_START) begin
              state_r <= S_ALLOC;
            end else begin
              status_r <= 1'b1;
              idle_r   <= 1'b1;
              state_r  <= S_RESP;
            end
          end else begin
            case (mode_r)
              lcts_pkg::MODE_CREATE: begin
                state_r <= S_ALLOC;
              end
              lcts_pkg::MODE_YIELD: begin
                state_r <= S_DISPATCH;
              end
              lcts_pkg::MODE_LOCK: begin
                if (!lk_ok_r || hold == cur_x) begin
                  status_r <= 1'b1;
                  state_r  <= S_RESP;
                end else if (hold == NO_T) begin
                  holder_r[lsel_r] <= cur_x;
                  state_r          <= S_RESP;
                end else begin
                  push_t_r <= cur_r;
                  state_r  <= S_LQ_PUSH;
                end
              end
              lcts_pkg::MODE_UNLOCK: begin
                if (!lk_ok_r || hold != cur_x) begin
                  status_r <= 1'b1;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_RELEASE;
                end
              end
              lcts_pkg::MODE_WAIT: begin
                if (!cv_ok_r || hold != cur_x) begin
                  status_r <= 1'b1;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_RELEASE;
                end
              end
              lcts_pkg::MODE_SIGNAL, lcts_pkg::MODE_BROADCAST: begin
                if (!cv_ok_r) begin
                  status_r <= 1'b1;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_CV_POP;
                end
              end
              lcts_pkg::MODE_FINISH: begin
                live_r[cur_r] <= 1'b0;
                lsel_r        <= '0;
                state_r       <= S_FINISH;
              end
              default: begin
                status_r <= 1'b1;
                state_r  <= S_RESP;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (!live_r[scan_r]) begin
            live_r[scan_r] <= 1'b1;
            pend_r[scan_r] <= NO_L;
            newt_r         <= scan_r;
            if (!started_r) begin
              started_r <= 1'b1;
              cur_r     <= scan_r;
            end
            state_r <= S_RESP;
          end else if (scan_r == TW'(THREADS - 1)) begin
            status_r <= 1'b1;
            idle_r   <= !started_r;
            state_r  <= S_RESP;
          end else begin
            scan_r <= scan_r + TW'(1);
          end
        end
        S_RELEASE: begin
          // Hand the lock straight to the oldest waiter, if any
          if (lq_h < NO_T) begin
            holder_r[lsel_r] <= lq_h;
            lqh_r[lsel_r]    <= (wn < NO_T) ? wn : NO_T;
            if (wn >= NO_T) begin
              lqt_r[lsel_r] <= NO_T;
            end
          end else begin
            holder_r[lsel_r] <= NO_T;
          end
          state_r <= (mode_r == lcts_pkg::MODE_UNLOCK) ? S_RESP : S_CV_PUSH;
        end
        S_LQ_PUSH: begin
          wnext_r[push_t_r] <= NO_T;
          lqt_r[lsel_r]     <= IW'(push_t_r);
          if (lq_h >= NO_T) begin
            lqh_r[lsel_r] <= IW'(push_t_r);
            state_r       <= S_DISPATCH;
          end else if (lq_t < NO_T) begin
            link_r  <= TW'(lq_t);
            state_r <= S_WN_LINK;
          end else begin
            state_r <= S_DISPATCH;
          end
        end
        S_WN_LINK: begin
          wnext_r[link_r] <= IW'(push_t_r);
          state_r         <= S_DISPATCH;
        end
        S_CV_PUSH: begin
          wnext_r[cur_r]   <= NO_T;
          pend_r[cur_r]    <= PW'(lk_r);
          cv_vld_r[qi_r]   <= 1'b1;
          push_t_r         <= cur_r;
          if (cv_h < NO_T && cv_t < NO_T) begin
            link_r  <= TW'(cv_t);
            state_r <= S_WN_LINK;
          end else begin
            state_r <= S_DISPATCH;
          end
        end
        S_CV_READ: begin
          state_r <= S_CV_POP;
        end
        S_CV_POP: begin
          if (cv_h >= NO_T || mode_r == lcts_pkg::MODE_SIGNAL) begin
            state_r <= S_RESP;
          end else begin
            state_r <= S_CV_READ;
          end
        end
        S_FINISH: begin
          // Orphan every lock the finishing thread still holds
          if (hold == cur_x) begin
            holder_r[lsel_r] <= ORPH;
          end
          if (lsel_r == LW'(LOCKS - 1)) begin
            state_r <= S_DISPATCH;
          end else begin
            lsel_r <= lsel_r + LW'(1);
          end
        end
        S_DISPATCH: begin
          if (cnt_r == '0) begin
            // Nothing can run: drop back to the reset state
            started_r <= 1'b0;
            cur_r     <= '0;
            live_r    <= '0;
            head_r    <= '0;
            cv_vld_r  <= '0;
            for (int i = 0; i < LOCKS; i++) begin
              holder_r[i] <= NO_T;
              lqh_r[i]    <= NO_T;
              lqt_r[i]    <= NO_T;
            end
            for (int i = 0; i < THREADS; i++) begin
              pend_r[i] <= NO_L;
            end
            idle_r  <= 1'b1;
            state_r <= S_RESP;
          end else begin
            disp_t_r <= rq_r[head_r];
            head_r   <= head_inc;
            cnt_r    <= cnt_r - CW'(1);
            state_r  <= S_RELOCK;
          end
        end
        S_RELOCK: begin
          if (32'(pend_cur) < LOCKS) begin
            pend_r[disp_t_r] <= NO_L;
            if (hold == NO_T) begin
              holder_r[hold_addr] <= IW'(disp_t_r);
              cur_r               <= disp_t_r;
              state_r             <= S_RESP;
            end else if (hold != IW'(disp_t_r)) begin
              push_t_r <= disp_t_r;
              lsel_r   <= hold_addr;
              state_r  <= S_LQ_PUSH;
            end else begin
              cur_r   <= disp_t_r;
              state_r <= S_RESP;
            end
          end else begin
            cur_r   <= disp_t_r;
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (rq_push && cnt_r < CW'(THREADS)) begin
        rq_r[rq_widx] <= rq_val;
        cnt_r         <= cnt_r + CW'(1);
      end
    end
  end

endmodule

/* rtl/core/lock_condvar_thread_scheduler.sv */
// Top level of the lock and condition-variable thread scheduler.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    in_tdata: request
//   out_     master     out_tvalid/out_tready  out_tdata: status and dispatch
//
// A request passes through accept, decode, response and the result transaction,
// plus any extra sequencer steps: create scans ids (up to THREADS), finish scans all
// LOCKS holders, broadcast re-reads and pops the queue for each further woken waiter, queue
// updates add push and link steps, and a dispatch pops threads until one can run, re-queuing any that wait on a lock.
// Synchronous reset clears all control state at once; there is no clearing pass.
// A result waits in the output register; the next request is taken once it is gone.
module lock_condvar_thread_scheduler #(
  parameter int THREADS = 16,
  parameter int LOCKS   = 16,
  parameter int CONDS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] mode, [7:4] lock_id, [9:8] cond_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] status, [4:1] active_thread, [5] idle,
                                  // [9:6] new_thread
);

  lcts_pkg::req_t  req;
  lcts_pkg::resp_t resp;
  lcts_pkg::resp_t out_resp_r;
  logic            out_valid_r;
  logic            ctrl_ready;
  logic            resp_valid;

  assign req.mode    = in_tdata[3:0];
  assign req.lock_id = in_tdata[7:4];
  assign req.cond_id = in_tdata[9:8];

  lcts_ctrl #(
    .THREADS (THREADS),
    .LOCKS   (LOCKS),
    .CONDS   (CONDS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid && !out_valid_r),
    .req        (req),
    .req_ready  (ctrl_ready),
    .resp_valid (resp_valid),
    .resp       (resp)
  );

  assign in_tready  = ctrl_ready && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_resp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_valid) begin
      out_valid_r <= 1'b1;
      out_resp_r  <= resp;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

/* rtl/core/lcts_chk.sv */
// Port-level checker for the scheduler, bound to the top level.
module lcts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_idle_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4:1] == 4'd0)
    else $error("idle result reports a running thread");

  a_idle_no_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[9:6] == 4'd0)
    else $error("idle result reports a new thread");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("request taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind lock_condvar_thread_scheduler lcts_chk u_lcts_chk (.*);

/* tb/testbench.sv */
// Self-checking testbench for the lock and condition-variable thread scheduler.
module testbench;

  localparam int NTHR = 16;
  localparam int NLCK = 16;
  localparam int NCND = 4;
  localparam int NONE = NTHR;
  localparam int ORPHAN = NTHR + 1;
  localparam int NOLOCK = NLCK;
  localparam logic [3:0] MODE_BAD_LO = 4'd9;
  localparam logic [3:0] MODE_BAD_HI = 4'd15;
  localparam int RAND_ITEMS = 1750;
  localparam int QUIET_ITEMS = 250;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]      mode;
    logic [3:0]      lk;
    logic [1:0]      cv;
    logic            typed;
    lcts_pkg::resp_t exp;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  // shadow scheduler state
  bit started;
  int cur_thr;
  bit live [NTHR];
  int rdy [NTHR];
  int rdy_head, rdy_cnt;
  int holder [NLCK];
  int nxt [NTHR];
  int lq_head [NLCK], lq_tail [NLCK];
  int cq_head [NLCK*NCND], cq_tail [NLCK*NCND];
  int relock [NTHR];

  lcts_pkg::resp_t expected_resp [$];
  int    mismatches;
  bit    quiet;
  int    quiet_cyc = 0;

  lock_condvar_thread_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void sched_clear();
    started = 0;
    cur_thr = 0;
    rdy_head = 0;
    rdy_cnt = 0;
    for (int i = 0; i < NTHR; i++) begin
      live[i] = 0;
      rdy[i] = 0;
      nxt[i] = 0;
      relock[i] = NOLOCK;
    end
    for (int i = 0; i < NLCK; i++) begin
      holder[i] = NONE;
      lq_head[i] = NONE;
      lq_tail[i] = NONE;
    end
    for (int i = 0; i < NLCK*NCND; i++) begin
      cq_head[i] = NONE;
      cq_tail[i] = NONE;
    end
  endfunction

  function automatic void ready_add(int t);
    if (rdy_cnt < NTHR && t < NTHR) begin
      rdy[(rdy_head + rdy_cnt) % NTHR] = t;
      rdy_cnt++;
    end
  endfunction

  function automatic void lockq_add(int lk, int t);
    if (t >= NTHR) return;
    nxt[t] = NONE;
    if (lq_head[lk] >= NTHR) lq_head[lk] = t;
    else if (lq_tail[lk] < NTHR) nxt[lq_tail[lk]] = t;
    lq_tail[lk] = t;
  endfunction

  function automatic int lockq_take(int lk);
    int t;
    t = lq_head[lk];
    if (t >= NTHR) return NONE;
    lq_head[lk] = nxt[t];
    if (lq_head[lk] >= NTHR) begin
      lq_head[lk] = NONE;
      lq_tail[lk] = NONE;
    end
    return t;
  endfunction

  function automatic void condq_add(int q, int t);
    if (t >= NTHR) return;
    nxt[t] = NONE;
    if (cq_head[q] >= NTHR) cq_head[q] = t;
    else if (cq_tail[q] < NTHR) nxt[cq_tail[q]] = t;
    cq_tail[q] = t;
  endfunction

  function automatic int condq_take(int q);
    int t;
    t = cq_head[q];
    if (t >= NTHR) return NONE;
    cq_head[q] = nxt[t];
    if (cq_head[q] >= NTHR) begin
      cq_head[q] = NONE;
      cq_tail[q] = NONE;
    end
    return t;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < NTHR; i++) begin
      if (!live[i]) begin
        live[i] = 1;
        relock[i] = NOLOCK;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void hand_off(int lk);
    int h;
    h = lockq_take(lk);
    holder[lk] = NONE;
    if (h < NTHR) begin
      holder[lk] = h;
      ready_add(h);
    end
  endfunction

  // woken waiters retake their lock here, or queue on it and are skipped
  function automatic bit pick_next();
    int t, lk;
    while (rdy_cnt > 0) begin
      t = rdy[rdy_head];
      rdy_head = (rdy_head + 1) % NTHR;
      rdy_cnt--;
      lk = relock[t];
      if (lk < NLCK) begin
        relock[t] = NOLOCK;
        if (holder[lk] == NONE) holder[lk] = t;
        else if (holder[lk] != t) begin
          lockq_add(lk, t);
          continue;
        end
      end
      cur_thr = t;
      return 1;
    end
    return 0;
  endfunction

  function automatic lcts_pkg::resp_t sched_predict(lcts_pkg::req_t r);
    lcts_pkg::resp_t o;
    int lk, q, id, cur;
    bit sw;
    o = '0;
    lk = int'(r.lock_id);
    q = lk * NCND + int'(r.cond_id);
    cur = cur_thr;
    sw = 0;
    if (!started) begin
      id = (r.mode == lcts_pkg::MODE_START) ? lowest_free() : -1;
      if (id >= 0) begin
        started = 1;
        cur_thr = id;
        o.new_thread = 4'(id);
      end else begin
        o.status = 1;
        o.idle = 1;
      end
    end else begin
      case (r.mode)
        lcts_pkg::MODE_CREATE: begin
          id = lowest_free();
          if (id < 0) o.status = 1;
          else begin
            o.new_thread = 4'(id);
            ready_add(id);
          end
        end
        lcts_pkg::MODE_YIELD: begin
          ready_add(cur);
          sw = 1;
        end
        lcts_pkg::MODE_LOCK: begin
          if (holder[lk] == cur) o.status = 1;
          else if (holder[lk] == NONE) holder[lk] = cur;
          else begin
            lockq_add(lk, cur);
            sw = 1;
          end
        end
        lcts_pkg::MODE_UNLOCK: begin
          if (holder[lk] != cur) o.status = 1;
          else hand_off(lk);
        end
        lcts_pkg::MODE_WAIT: begin
          if (holder[lk] != cur) o.status = 1;
          else begin
            hand_off(lk);
            condq_add(q, cur);
            relock[cur] = lk;
            sw = 1;
          end
        end
        lcts_pkg::MODE_SIGNAL, lcts_pkg::MODE_BROADCAST: begin
          for (int i = 0; i < NTHR; i++) begin
            id = condq_take(q);
            if (id >= NTHR) break;
            ready_add(id);
            if (r.mode == lcts_pkg::MODE_SIGNAL) break;
          end
        end
        lcts_pkg::MODE_FINISH: begin
          live[cur] = 0;
          for (int i = 0; i < NLCK; i++)
            if (holder[i] == cur) holder[i] = ORPHAN;
          sw = 1;
        end
        default: o.status = 1;
      endcase
      if (sw && !pick_next()) begin
        sched_clear();
        o.idle = 1;
      end
    end
    if (!o.idle) o.active_thread = 4'(cur_thr);
    return o;
  endfunction

  function automatic lcts_pkg::req_t random_req();
    lcts_pkg::req_t r;
    int p, n;
    int held [$];
    r.lock_id = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 3))
                                             : 4'($urandom_range(0, 15));
    r.cond_id = ($urandom_range(0, 99) < 80) ? 2'($urandom_range(0, 1))
                                             : 2'($urandom_range(0, 3));
    p = $urandom_range(0, 99);
    if (!started) r.mode = (p < 80) ? lcts_pkg::MODE_START : 4'($urandom_range(0, 15));
    else if (p < 4)  r.mode = lcts_pkg::MODE_START;
    else if (p < 16) r.mode = lcts_pkg::MODE_CREATE;
    else if (p < 28) r.mode = lcts_pkg::MODE_YIELD;
    else if (p < 46) r.mode = lcts_pkg::MODE_LOCK;
    else if (p < 62) r.mode = lcts_pkg::MODE_UNLOCK;
    else if (p < 72) r.mode = lcts_pkg::MODE_WAIT;
    else if (p < 80) r.mode = lcts_pkg::MODE_SIGNAL;
    else if (p < 86) r.mode = lcts_pkg::MODE_BROADCAST;
    else if (p < 94) r.mode = lcts_pkg::MODE_FINISH;
    else if (p < 97) r.mode = 4'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
    else r.mode = 4'($urandom_range(0, 15));
    // mostly unlock or wait on a lock the running thread actually holds
    if (started && (r.mode == lcts_pkg::MODE_UNLOCK || r.mode == lcts_pkg::MODE_WAIT) &&
        $urandom_range(0, 3) != 0) begin
      for (int i = 0; i < NLCK; i++)
        if (holder[i] == cur_thr) held.push_back(i);
      n = held.size();
      if (n > 0) r.lock_id = 4'(held[$urandom_range(0, n - 1)]);
    end
    return r;
  endfunction

  task automatic send_req(lcts_pkg::req_t r, logic typed, lcts_pkg::resp_t typed_resp);
    lcts_pkg::resp_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tdata = {6'd0, r};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    p = sched_predict(r);
    expected_resp.push_back(typed ? typed_resp : p);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // result side: stall in bursts, steady once the run goes quiet
  int  rx_left = 0;
  bit  rx_on = 0;
  always @(negedge clk) begin
    if (quiet) begin
      out_tready = 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_on = !rx_on;
        rx_left = rx_on ? $urandom_range(1, 60) : $urandom_range(1, 19);
      end
      rx_left--;
      out_tready = rx_on;
    end
  end

  always @(posedge clk) begin
    lcts_pkg::resp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[9:0];
      if (expected_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %h", got);
      end else begin
        want = expected_resp.pop_front();
        if (got.status !== want.status || got.active_thread !== want.active_thread ||
            got.idle !== want.idle || got.new_thread !== want.new_thread) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d run=%0d idle=%0d new=%0d,",
                      " got st=%0d run=%0d idle=%0d new=%0d"},
                     want.status, want.active_thread, want.idle, want.new_thread,
                     got.status, got.active_thread, got.idle, got.new_thread);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cyc <= 0;
    else quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc > STALL_LIMIT) begin
      $display("lock_condvar_thread_scheduler regression: fail");
      $finish;
    end
  end

  plan_row_t plan [] = '{
    '{lcts_pkg::MODE_YIELD,     4'd0,  2'd0, 1'b1, '{4'd0, 1'b1, 4'd0, 1'b1}},
    '{lcts_pkg::MODE_START,     4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 4'd0, 1'b0}},
    '{lcts_pkg::MODE_START,     4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 4'd0, 1'b1}},
    '{lcts_pkg::MODE_CREATE,    4'd0,  2'd0, 1'b1, '{4'd1, 1'b0, 4'd0, 1'b0}},
    '{lcts_pkg::MODE_LOCK,      4'd15, 2'd3, 1'b1, '{4'd0, 1'b0, 4'd0, 1'b0}},
    '{lcts_pkg::MODE_LOCK,      4'd15, 2'd3, 1'b1, '{4'd0, 1'b0, 4'd0, 1'b1}},
    '{lcts_pkg::MODE_UNLOCK,    4'd3,  2'd0, 1'b1, '{4'd0, 1'b0, 4'd0, 1'b1}},
    '{lcts_pkg::MODE_WAIT,      4'd15, 2'd3, 1'b0, '0},
    '{lcts_pkg::MODE_LOCK,      4'd15, 2'd3, 1'b0, '0},
    '{lcts_pkg::MODE_SIGNAL,    4'd15, 2'd3, 1'b0, '0},
    '{lcts_pkg::MODE_UNLOCK,    4'd15, 2'd0, 1'b0, '0},
    '{lcts_pkg::MODE_BROADCAST, 4'd0,  2'd0, 1'b0, '0},
    '{MODE_BAD_LO,              4'd0,  2'd0, 1'b1, '{4'd0, 1'b0, 4'd1, 1'b1}},
    '{MODE_BAD_HI,              4'd15, 2'd3, 1'b1, '{4'd0, 1'b0, 4'd1, 1'b1}},
    '{lcts_pkg::MODE_YIELD,     4'd0,  2'd0, 1'b0, '0},
    '{lcts_pkg::MODE_FINISH,    4'd0,  2'd0, 1'b0, '0},
    '{lcts_pkg::MODE_LOCK,      4'd15, 2'd0, 1'b0, '0},
    '{lcts_pkg::MODE_START,     4'd0,  2'd0, 1'b0, '0},
    '{lcts_pkg::MODE_FINISH,    4'd0,  2'd0, 1'b0, '0}
  };

  initial begin
    lcts_pkg::req_t  r;
    lcts_pkg::resp_t nil;
    int    wait_cyc;
    nil = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    quiet = 0;
    mismatches = 0;
    sched_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (plan[i]) begin
      r.mode = plan[i].mode;
      r.lock_id = plan[i].lk;
      r.cond_id = plan[i].cv;
      send_req(r, plan[i].typed, plan[i].exp);
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_ITEMS) quiet = 1;
      send_req(random_req(), 1'b0, nil);
    end
    wait_cyc = 0;
    while (expected_resp.size() != 0 && wait_cyc < STALL_LIMIT) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_resp.size() == 0)
      $display("lock_condvar_thread_scheduler regression: pass");
    else
      $display("lock_condvar_thread_scheduler regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/core/lcts_pkg.sv
rtl/core/lcts_ram.sv
rtl/core/lcts_ctrl.sv
rtl/core/lock_condvar_thread_scheduler.sv
rtl/core/lcts_chk.sv
tb/testbench.sv
